[sv/rtc_alm_pkg.sv]
package rtc_alm_pkg;

  // sub-second resolution: 2**SUBSEC_BITS ticks per second (8..15)
  localparam int unsigned SUBSEC_BITS = 11;

  // field widths fixed by the interface
  localparam int unsigned MS_W        = 31;
  localparam int unsigned SUBSEC_FLD_W = 11;

  // zero-extension width that covers both the subsec field and the tick count
  localparam int unsigned SUB_EXT_W = SUBSEC_BITS + SUBSEC_FLD_W;

  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned MS_DIV    = MS_PER_S / 8;      // 125, 8 divides 2**SUBSEC_BITS
  localparam int unsigned TICK_MIN  = 3;

  // ms = 125*a + b, ticks = a * 2**(SUBSEC_BITS-3) + frac_tab[b]
  localparam int unsigned QUOT_W    = 25;                // ms / 125 < 2**25
  localparam int unsigned REM_MS_W  = 7;                 // b < 125
  localparam int unsigned TAB_W     = SUBSEC_BITS - 2;
  localparam int unsigned TICKS_W   = SUBSEC_BITS + 23;
  localparam int unsigned WHOLE_W   = 22;                // whole seconds < 2**22

  // reciprocal constants, exact over the ranges used
  localparam logic [31:0] RECIP_125 = 32'd2199023256;    // x < 2**31, shift 38
  localparam int unsigned SHIFT_125 = 38;
  localparam logic [15:0] RECIP_675 = 16'd49711;         // x < 2**15, shift 25
  localparam int unsigned SHIFT_675 = 25;
  localparam logic [13:0] RECIP_225 = 14'd9321;          // x < 2**13, shift 21
  localparam int unsigned SHIFT_225 = 21;
  localparam logic [10:0] RECIP_15  = 11'd1093;          // x < 2**10, shift 14
  localparam int unsigned SHIFT_15  = 14;

  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned HOUR_PER_DAY = 24;
  localparam int unsigned YEAR_MAX     = 99;
  localparam int unsigned MONTH_DEC    = 12;

  localparam int unsigned NUM_STAGES = 12;

  typedef struct packed {
    logic [SUBSEC_BITS-1:0] sub;
    logic [5:0]             sec;
    logic [5:0]             min;
    logic [4:0]             hour;
    logic [4:0]             day;
    logic [3:0]             month;
    logic [6:0]             year;
  } now_t;

  typedef logic [TAB_W-1:0] frac_tab_t [MS_DIV];

  // ticks for the sub-125 ms remainder, round to nearest
  function automatic frac_tab_t gen_frac_tab();
    frac_tab_t t;
    for (int i = 0; i < MS_DIV; i++) begin
      t[i] = TAB_W'((i * (2 ** SUBSEC_BITS) + MS_PER_S / 2) / MS_PER_S);
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = gen_frac_tab();

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[sv/rtc_alarm_calendar_add.sv]
// rtc alarm calendar add
//
// takes a timeout in milliseconds and the current calendar time (sub-second
// down-counter, second, minute, hour, day, month, two-digit year) and returns
// the calendar time at which the alarm fires.
//
// input channel:  in_valid_i / in_ready_o, payload timeout_ms_i and now_*_i
// output channel: out_valid_o / out_ready_i, payload alarm_*_o
//
// one request is taken every cycle while the receiver does not stall;
// throughput is one result per cycle, set by the 12-stage pipeline in
// which each stage holds a multiply by a reciprocal or a constant, or adds
// and compares. when the receiver stalls, results pile up in the pipeline;
// empty stages still close up, so in_ready_o drops only once all 12 stages
// hold requests. reset clears all stage valid bits; payload registers are
// not reset. no configuration, no state kept between requests.

module rtc_alarm_calendar_add (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] timeout_ms_i,
  input  logic [10:0] now_subsec_i,
  input  logic [5:0]  now_second_i,
  input  logic [5:0]  now_minute_i,
  input  logic [4:0]  now_hour_i,
  input  logic [4:0]  now_day_i,
  input  logic [3:0]  now_month_i,
  input  logic [6:0]  now_year_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] alarm_subsec_o,
  output logic [5:0]  alarm_second_o,
  output logic [5:0]  alarm_minute_o,
  output logic [4:0]  alarm_hour_o,
  output logic [4:0]  alarm_day_o,
  output logic [3:0]  alarm_month_o,
  output logic [6:0]  alarm_year_o
);
  import rtc_alm_pkg::*;

  localparam int unsigned LAST = NUM_STAGES - 1;

  // stage valid bits and per-stage advance enables
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] stg_en;

  // calendar fields travel with the request through the stages that need them
  now_t                   tm_q     [0:10];

  // stage 0: ms / 125 by reciprocal multiply
  logic [MS_W-1:0]        ms_q;
  logic [QUOT_W-1:0]      p_q;
  // stage 1: quotient and remainder of ms / 125
  logic [QUOT_W-1:0]      a_q;
  logic [REM_MS_W-1:0]    b_q;
  // stage 2..: whole seconds, sub-second carry and alarm sub-second
  logic [WHOLE_W-1:0]     whole_q  [2:3];
  logic                   cy_q     [2:8];
  logic [SUBSEC_BITS-1:0] asub_q   [2:11];
  // day/hour/minute/second split of the whole seconds
  logic [4:0]             d_q      [3:9];
  logic [16:0]            rem_q    [4:5];
  logic [4:0]             h_q      [5:9];
  logic [11:0]            rem2_q   [6:7];
  logic [5:0]             m_q      [7:8];
  logic [5:0]             s_q;
  // calendar add
  logic [5:0]             sec_q    [9:11];
  logic [5:0]             min_q    [9:11];
  logic [1:0]             cmin_q;
  logic [4:0]             hour_q   [10:11];
  logic [5:0]             daysum_q;
  logic [4:0]             day_q;
  logic [3:0]             mon_q;
  logic [6:0]             yr_q;

  // a stage moves on when it is empty or the next stage moves on
  always_comb begin
    stg_en[LAST] = !vld_q[LAST] || out_ready_i;
    for (int i = LAST - 1; i >= 0; i--) begin
      stg_en[i] = !vld_q[i] || stg_en[i+1];
    end
  end

  assign in_ready_o  = stg_en[0];
  assign out_valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stg_en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // combinational work of each stage
  // ---------------------------------------------------------------------------
  logic [SUB_EXT_W-1:0]   sub_in_ext;
  now_t                   tm_in;
  logic [62:0]            prod125;

  logic [31:0]            ms_rem;

  logic [TICKS_W-1:0]     ticks_raw;
  logic [TICKS_W-1:0]     ticks;
  logic [SUBSEC_BITS:0]   frac_sum;

  logic [30:0]            prod_day;
  logic [16:0]            rem_n;
  logic [26:0]            prod_hr;
  logic [11:0]            rem2_n;
  logic [20:0]            prod_min;
  logic [5:0]             s_n;

  logic [6:0]             sec_sum;
  logic [1:0]             csec;
  logic [6:0]             sec_n;
  logic [6:0]             min_sum;
  logic [1:0]             cmin;
  logic [6:0]             min_n;

  logic [5:0]             hour_sum;
  logic [1:0]             chr;
  logic [5:0]             hour_n;
  logic [5:0]             day_sum;

  logic [4:0]             mlen;
  logic [5:0]             day_n;
  logic [3:0]             mon_n;
  logic [7:0]             yr_inc;
  logic [6:0]             yr_n;

  logic [SUB_EXT_W-1:0]   asub_ext;

  always_comb begin
    // stage 0: input capture, ms * (2**38 / 125)
    sub_in_ext     = SUB_EXT_W'(now_subsec_i);
    tm_in.sub      = sub_in_ext[SUBSEC_BITS-1:0];
    tm_in.sec      = now_second_i;
    tm_in.min      = now_minute_i;
    tm_in.hour     = now_hour_i;
    tm_in.day      = now_day_i;
    tm_in.month    = now_month_i;
    tm_in.year     = now_year_i;
    prod125        = 63'(timeout_ms_i) * 63'(RECIP_125);

    // stage 1: remainder of ms / 125
    ms_rem         = 32'(ms_q) - 32'(p_q) * 32'(MS_DIV);

    // stage 2: ticks, minimum delay, sub-second add
    ticks_raw      = (TICKS_W'(a_q) << (SUBSEC_BITS - 3)) + TICKS_W'(FRAC_TAB[b_q]);
    ticks          = (ticks_raw <= TICKS_W'(TICK_MIN)) ? TICKS_W'(TICK_MIN) : ticks_raw;
    // elapsed part of this second plus the fractional delay
    frac_sum       = {1'b0, ~tm_q[1].sub} + {1'b0, ticks[SUBSEC_BITS-1:0]};

    // stage 3: days = whole / 86400 = (whole >> 7) / 675
    prod_day       = 31'(whole_q[2][WHOLE_W-1:7]) * 31'(RECIP_675);

    // stage 4: seconds left in the day
    rem_n          = 17'(23'(whole_q[3]) - 23'(d_q[3]) * 23'(SEC_PER_DAY));

    // stage 5: hours = rem / 3600 = (rem >> 4) / 225
    prod_hr        = 27'(rem_q[4][16:4]) * 27'(RECIP_225);

    // stage 6: seconds left in the hour
    rem2_n         = 12'(17'(rem_q[5]) - 17'(h_q[5]) * 17'(SEC_PER_HOUR));

    // stage 7: minutes = rem2 / 60 = (rem2 >> 2) / 15
    prod_min       = 21'(rem2_q[6][11:2]) * 21'(RECIP_15);

    // stage 8: seconds
    s_n            = 6'(12'(rem2_q[7]) - 12'(m_q[7]) * 12'(SEC_PER_MIN));

    // stage 9: second and minute with carries (sums stay below 2*60 + 5)
    sec_sum        = 7'(tm_q[8].sec) + 7'(s_q) + 7'(cy_q[8]);
    if (sec_sum >= 7'(2 * SEC_PER_MIN)) begin
      csec = 2'd2;
    end else if (sec_sum >= 7'(SEC_PER_MIN)) begin
      csec = 2'd1;
    end else begin
      csec = 2'd0;
    end
    sec_n          = sec_sum - 7'(csec) * 7'(SEC_PER_MIN);
    min_sum        = 7'(tm_q[8].min) + 7'(m_q[8]) + 7'(csec);
    if (min_sum >= 7'(2 * SEC_PER_MIN)) begin
      cmin = 2'd2;
    end else if (min_sum >= 7'(SEC_PER_MIN)) begin
      cmin = 2'd1;
    end else begin
      cmin = 2'd0;
    end
    min_n          = min_sum - 7'(cmin) * 7'(SEC_PER_MIN);

    // stage 10: hour and day
    hour_sum       = 6'(tm_q[9].hour) + 6'(h_q[9]) + 6'(cmin_q);
    if (hour_sum >= 6'(2 * HOUR_PER_DAY)) begin
      chr = 2'd2;
    end else if (hour_sum >= 6'(HOUR_PER_DAY)) begin
      chr = 2'd1;
    end else begin
      chr = 2'd0;
    end
    hour_n         = hour_sum - 6'(chr) * 6'(HOUR_PER_DAY);
    day_sum        = 6'(tm_q[9].day) + 6'(d_q[9]) + 6'(chr);

    // stage 11: month overflow, december and year wrap
    mlen           = days_in_month(tm_q[10].month, tm_q[10].year[1:0] == 2'd0);
    yr_inc         = 8'(tm_q[10].year) + 8'd1;
    day_n          = daysum_q;
    mon_n          = tm_q[10].month;
    yr_n           = tm_q[10].year;
    if (daysum_q > 6'(mlen)) begin
      day_n = daysum_q - 6'(mlen);
      if (tm_q[10].month >= 4'(MONTH_DEC)) begin
        mon_n = 4'd1;
        yr_n  = (yr_inc > 8'(YEAR_MAX)) ? 7'd0 : yr_inc[6:0];
      end else begin
        mon_n = tm_q[10].month + 4'd1;
      end
    end

    asub_ext       = SUB_EXT_W'(asub_q[11]);
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (stg_en[0]) begin
      ms_q     <= timeout_ms_i;
      p_q      <= prod125[SHIFT_125 +: QUOT_W];
      tm_q[0]  <= tm_in;
    end
    for (int i = 1; i <= 10; i++) begin
      if (stg_en[i]) begin
        tm_q[i] <= tm_q[i-1];
      end
    end

    if (stg_en[1]) begin
      a_q <= p_q;
      b_q <= ms_rem[REM_MS_W-1:0];
    end

    if (stg_en[2]) begin
      whole_q[2] <= ticks[SUBSEC_BITS +: WHOLE_W];
      cy_q[2]    <= frac_sum[SUBSEC_BITS];
      asub_q[2]  <= ~frac_sum[SUBSEC_BITS-1:0];
    end
    for (int i = 3; i <= 8; i++) begin
      if (stg_en[i]) begin
        cy_q[i] <= cy_q[i-1];
      end
    end
    for (int i = 3; i <= 11; i++) begin
      if (stg_en[i]) begin
        asub_q[i] <= asub_q[i-1];
      end
    end

    if (stg_en[3]) begin
      whole_q[3] <= whole_q[2];
      d_q[3]     <= prod_day[SHIFT_675 +: 5];
    end
    for (int i = 4; i <= 9; i++) begin
      if (stg_en[i]) begin
        d_q[i] <= d_q[i-1];
      end
    end

    if (stg_en[4]) begin
      rem_q[4] <= rem_n;
    end
    if (stg_en[5]) begin
      rem_q[5] <= rem_q[4];
      h_q[5]   <= prod_hr[SHIFT_225 +: 5];
    end
    for (int i = 6; i <= 9; i++) begin
      if (stg_en[i]) begin
        h_q[i] <= h_q[i-1];
      end
    end

    if (stg_en[6]) begin
      rem2_q[6] <= rem2_n;
    end
    if (stg_en[7]) begin
      rem2_q[7] <= rem2_q[6];
      m_q[7]    <= prod_min[SHIFT_15 +: 6];
    end
    if (stg_en[8]) begin
      m_q[8] <= m_q[7];
      s_q    <= s_n;
    end

    if (stg_en[9]) begin
      sec_q[9] <= sec_n[5:0];
      min_q[9] <= min_n[5:0];
      cmin_q   <= cmin;
    end
    for (int i = 10; i <= 11; i++) begin
      if (stg_en[i]) begin
        sec_q[i] <= sec_q[i-1];
        min_q[i] <= min_q[i-1];
      end
    end

    if (stg_en[10]) begin
      hour_q[10] <= hour_n[4:0];
      daysum_q   <= day_sum;
    end

    if (stg_en[11]) begin
      hour_q[11] <= hour_q[10];
      day_q      <= day_n[4:0];
      mon_q      <= mon_n;
      yr_q       <= yr_n;
    end
  end

  assign alarm_subsec_o = asub_ext[SUBSEC_FLD_W-1:0];
  assign alarm_second_o = sec_q[11];
  assign alarm_minute_o = min_q[11];
  assign alarm_hour_o   = hour_q[11];
  assign alarm_day_o    = day_q;
  assign alarm_month_o  = mon_q;
  assign alarm_year_o   = yr_q;

`ifndef SYNTHESIS
  // requests are refused only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input refused with room in the pipeline");

  // day count from the reciprocal multiply stays within the delay range
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (d_q[3] <= 5'd24))
    else $error("day quotient out of range");

  // minute and second split of the remaining seconds
  a_min_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (m_q[8] < 6'd60 && s_q < 6'd60))
    else $error("minute/second split out of range");

  // carried time fields land in range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alarm_second_o < 6'd60 && alarm_minute_o < 6'd60 &&
                     alarm_hour_o < 5'd24))
    else $error("alarm time field out of range");
`endif

endmodule
